/* src/eia_pkg.sv */
// Package for the event to interval alignment unit: widths, command and
// status codes, sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eia_pkg;
  localparam int IntDepth = 1024;
  localparam int EvtDepth = 256;
  localparam int IntAw = $clog2(IntDepth);
  localparam int EvtAw = $clog2(EvtDepth);
  localparam int TimeW = 44;
  localparam int SecW = 17;
  localparam logic [SecW-1:0] SecReset = 17'd900;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD_INT = 3'd1,
    CMD_ADD_EVT = 3'd2,
    CMD_ALIGN = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NOT_INC = 3'd1,
    ST_NOT_WHOLE = 3'd2,
    ST_RANGE = 3'd3,
    ST_FULL = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LAST,
    S_DISPATCH,
    S_BS_RD,
    S_BS_CMP,
    S_IN_RD,
    S_IN_CMP,
    S_QC_RD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

/* src/eia_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module eia_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/eia_div.sv */
// Signed divide of microseconds by one million: the magnitude is multiplied by
// a 64-bit reciprocal over four 32x32 products, then the remainder is checked.
// Uses eia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eia_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  output logic             done,
  output logic [63:0]      mag_q,
  output logic             neg,
  output logic             whole
);
  import eia_pkg::*;

  // ceil(2^83 / 1000000): exact floor quotient for magnitudes up to 2^63
  localparam logic [63:0] Recip = 64'd9671406556917033398;

  logic [63:0]  mag;
  logic [63:0]  prod;
  logic [127:0] acc;
  logic [2:0]   step;
  logic         busy;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  quot;
  logic [63:0]  back;

  assign quot = {20'd0, acc[126:83]};
  // quot * 1000000 as shifts: 2^20 - 2^16 + 2^14 + 2^9 + 2^6
  assign back = (quot << 20) - (quot << 16) + (quot << 14) + (quot << 9) + (quot << 6);

  always_comb begin
    mul_a = mag[31:0];
    mul_b = Recip[31:0];
    case (step)
      3'd1: mul_b = Recip[63:32];
      3'd2: mul_a = mag[63:32];
      3'd3: begin
        mul_a = mag[63:32];
        mul_b = Recip[63:32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (step == 3'd5);
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
        neg <= dividend[63];
        mag <= dividend[63] ? (~dividend + 64'd1) : dividend;
      end else if (busy) begin
        prod <= 64'(mul_a) * 64'(mul_b);
        step <= step + 3'd1;
        case (step)
          3'd1: acc <= {64'd0, prod};
          3'd2, 3'd3: acc <= acc + {32'd0, prod, 32'd0};
          3'd4: acc <= acc + {prod, 64'd0};
          3'd5: begin
            mag_q <= quot;
            whole <= (back == mag);
            busy <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

/* src/event_to_interval_alignment_unit.sv */
// Top level of the event to interval alignment unit.
// Depends on eia_pkg, eia_ram, eia_div.
// Usage:
//   One command per input transfer (valid/stall); one result per command on
//   the output channel (valid/stall). The interval duration register is
//   written over its own valid/ready channel while the unit is idle.
//   Commands are handled one at a time. Append event and align run the
//   divide by one million (four 32x32 reciprocal products and a remainder
//   check). Align then runs a binary search over the interval memory (up to
//   11 steps) when intervals are stored and the time is whole. A query in
//   range scans every stored event, then runs a binary search over the
//   interval memory when an event precedes the cutoff. The memories have
//   one read port each. The next command is accepted once the result has
//   been taken.
//   Reset clears both counts and sets the duration to 900 seconds; table
//   contents are left as they are. A stalled result is held in the output
//   register, and input stays stalled until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module event_to_interval_alignment_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  command,
  input  wire logic signed [43:0]          interval_start,
  input  wire logic signed [63:0]          event_micros,
  input  wire logic [9:0]                  query_interval,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       status,
  output logic                             first_valid,
  output logic [9:0]                       first_interval,
  output logic                             inside_interval,
  output logic                             event_found,
  output logic [7:0]                       found_event,
  output logic [9:0]                       intervals_since,
  output logic [43:0]                      seconds_to_cutoff,
  output logic                             in_current,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [eia_pkg::SecW-1:0]    cfg_data
);
  import eia_pkg::*;

  state_t state, state_next;

  logic [SecW-1:0]   isec;
  logic [IntAw:0]    icount;
  logic [EvtAw:0]    ecount;
  logic [TimeW-1:0]  last_start;

  logic [2:0]        cmd_r;
  logic [TimeW-1:0]  start_r;
  logic [63:0]       micros_r;
  logic [IntAw-1:0]  q_r;

  logic              div_start, div_done, div_neg, div_whole;
  logic [63:0]       div_mag;
  logic signed [63:0] tsec;
  logic              t_whole;

  logic [IntAw:0]    lo, hi;
  logic [IntAw-1:0]  mid;
  logic              qmode;
  logic signed [TimeW:0] key;

  logic              have;
  logic [EvtAw-1:0]  best;
  logic signed [TimeW-1:0] bt;
  logic [EvtAw:0]    scan_i;
  logic signed [TimeW:0] qcut;

  logic              iwe, ewe;
  logic [IntAw-1:0]  iwaddr, iraddr;
  logic [TimeW-1:0]  iwdata, irdata;
  logic [EvtAw-1:0]  ewaddr, eraddr;
  logic [TimeW-1:0]  ewdata, erdata;

  logic signed [TimeW:0] rd_cut;
  logic signed [TimeW-1:0] rd_start;

  eia_ram #(.Width(TimeW), .Depth(IntDepth)) u_iram (
    .clk(clk), .we(iwe), .waddr(iwaddr), .wdata(iwdata),
    .raddr(iraddr), .rdata(irdata));
  eia_ram #(.Width(TimeW), .Depth(EvtDepth)) u_eram (
    .clk(clk), .we(ewe), .waddr(ewaddr), .wdata(ewdata),
    .raddr(eraddr), .rdata(erdata));

  eia_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(micros_r),
    .done(div_done), .mag_q(div_mag), .neg(div_neg), .whole(div_whole));

  assign rd_start = $signed(irdata);
  assign rd_cut = {rd_start[TimeW-1], rd_start} + $signed({1'b0, {(TimeW-SecW){1'b0}}, isec});
  assign mid = IntAw'(lo + ((hi - lo) >> 1));
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_stall = !((state == S_IDLE) && !out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      isec <= SecReset;
    end else if (cfg_valid && cfg_ready) begin
      isec <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) state_next = S_DIV;
      S_DIV: begin
        if (cmd_r == CMD_ADD_EVT || cmd_r == CMD_ALIGN) begin
          div_start = 1'b1;
          state_next = S_LAST;
        end else begin
          state_next = S_DISPATCH;
        end
      end
      S_LAST: if (div_done) state_next = S_DISPATCH;
      S_DISPATCH: begin
        state_next = S_DONE;
        if (cmd_r == CMD_ALIGN && icount != '0 && t_whole) state_next = S_BS_RD;
        if (cmd_r == CMD_QUERY && {1'b0, q_r} < icount && ecount != '0) state_next = S_QC_RD;
      end
      S_BS_RD: state_next = (lo < hi) ? S_BS_CMP : S_IN_RD;
      S_BS_CMP: state_next = S_BS_RD;
      S_IN_RD: state_next = (lo < icount) ? S_IN_CMP : S_DONE;
      S_IN_CMP: state_next = S_DONE;
      S_QC_RD: state_next = S_SCAN_RD;
      S_SCAN_RD: state_next = (scan_i < ecount) ? S_SCAN_CMP : (have ? S_BS_RD : S_DONE);
      S_SCAN_CMP: state_next = S_SCAN_RD;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    iraddr = mid;
    if (state == S_IN_RD || state == S_IN_CMP) iraddr = IntAw'(lo);
    if (state == S_QC_RD || state == S_DISPATCH) iraddr = q_r;
    eraddr = EvtAw'(scan_i);
  end

  logic [63:0] tsec_pos;
  logic signed [TimeW:0] diff;
  assign tsec_pos = div_mag;
  assign diff = qcut - {bt[TimeW-1], bt};

  always_ff @(posedge clk) begin
    iwe <= 1'b0;
    ewe <= 1'b0;
    if (rst) begin
      icount <= '0;
      ecount <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          cmd_r <= command;
          start_r <= interval_start;
          micros_r <= event_micros;
          q_r <= query_interval;
          status <= ST_OK;
          first_valid <= 1'b0; first_interval <= '0; inside_interval <= 1'b0;
          event_found <= 1'b0; found_event <= '0; intervals_since <= '0;
          seconds_to_cutoff <= '0; in_current <= 1'b0;
        end
        S_LAST: if (div_done) begin
          tsec <= div_neg ? -$signed(tsec_pos) : $signed(tsec_pos);
          t_whole <= div_whole;
        end
        S_DISPATCH: begin
          lo <= '0;
          hi <= icount;
          have <= 1'b0;
          scan_i <= '0;
          qmode <= (cmd_r == CMD_QUERY);
          key <= tsec[TimeW:0];
          unique case (cmd_r)
            CMD_CLEAR: begin
              icount <= '0;
              ecount <= '0;
            end
            CMD_ADD_INT: begin
              if (icount >= (IntAw+1)'(IntDepth)) status <= ST_FULL;
              else if (icount != '0 && !($signed(last_start) < $signed(start_r)))
                status <= ST_NOT_INC;
              else begin
                iwe <= 1'b1;
                iwaddr <= IntAw'(icount);
                iwdata <= start_r;
                last_start <= start_r;
                icount <= icount + (IntAw+1)'(1);
              end
            end
            CMD_ADD_EVT: begin
              if (ecount >= (EvtAw+1)'(EvtDepth)) status <= ST_FULL;
              else if (!t_whole) status <= ST_NOT_WHOLE;
              else if (tsec < -(64'sd1 <<< 43) || tsec >= (64'sd1 <<< 43)) status <= ST_RANGE;
              else begin
                ewe <= 1'b1;
                ewaddr <= EvtAw'(ecount);
                ewdata <= tsec[TimeW-1:0];
                ecount <= ecount + (EvtAw+1)'(1);
              end
            end
            CMD_ALIGN: if (icount != '0 && !t_whole) status <= ST_NOT_WHOLE;
            CMD_QUERY: if (!({1'b0, q_r} < icount)) status <= ST_RANGE;
            default: ;
          endcase
        end
        S_BS_CMP: begin
          if (rd_cut <= key) lo <= {1'b0, mid} + (IntAw+1)'(1);
          else hi <= {1'b0, mid};
        end
        S_IN_CMP: begin
          if (!qmode) begin
            first_valid <= 1'b1;
            first_interval <= IntAw'(lo);
            inside_interval <= ($signed({rd_start[TimeW-1], rd_start}) <= key) &&
                               (key < rd_cut);
          end else if (lo[IntAw-1:0] <= q_r || 1'b0) begin
            if ({1'b0, lo[IntAw-1:0]} <= {1'b0, q_r}) begin
              event_found <= 1'b1;
              found_event <= best;
              intervals_since <= q_r - lo[IntAw-1:0];
              seconds_to_cutoff <= diff[TimeW] ? '1 : diff[TimeW-1:0];
              in_current <= (rd_start <= bt) && (key < rd_cut) && (lo[IntAw-1:0] == q_r);
            end
          end
        end
        S_QC_RD: qcut <= rd_cut;
        S_SCAN_RD: begin
          if (!(scan_i < ecount) && have) begin
            key <= {bt[TimeW-1], bt};
            lo <= '0;
            hi <= icount;
          end
        end
        S_SCAN_CMP: begin
          if ($signed({erdata[TimeW-1], erdata}) < qcut &&
              (!have || bt < $signed(erdata))) begin
            have <= 1'b1;
            best <= EvtAw'(scan_i);
            bt <= $signed(erdata);
          end
          scan_i <= scan_i + (EvtAw+1)'(1);
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input accepted while result pending");
  assert property (@(posedge clk) disable iff (rst) icount <= (IntAw+1)'(IntDepth))
    else $error("interval count overflow");
  assert property (@(posedge clk) disable iff (rst) ecount <= (EvtAw+1)'(EvtDepth))
    else $error("event count overflow");
  assert property (@(posedge clk) disable iff (rst) (state == S_BS_CMP) |-> (lo < hi))
    else $error("search window empty");
endmodule
`default_nettype wire
